[rtl/rssi_link_quality_estimator_macros.svh]
// ----------------------------------------------------------------------------
// rssi link quality estimator assertion macros
// Shorthand for clocked assertions on clk with rst_n as disable.
// ----------------------------------------------------------------------------
`ifndef RSSI_LINK_QUALITY_ESTIMATOR_MACROS_SVH
`define RSSI_LINK_QUALITY_ESTIMATOR_MACROS_SVH

// same-cycle implication
`define RLQE_ASSERT_IMP(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("rlqe assertion failed");

// next-cycle implication
`define RLQE_ASSERT_NEXT(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("rlqe assertion failed");

`endif

[rtl/rlqe_pkg.sv]
// ----------------------------------------------------------------------------
// rlqe_pkg
// Types, constants and codes shared by the rssi link quality estimator.
// ----------------------------------------------------------------------------
`default_nettype none

package rlqe_pkg;

    // default node table depth
    localparam int NODE_COUNT_DEF = 4;

    // register reset and score constants (rssi and score values in q8.8)
    localparam logic [15:0]        EXP_INTERVAL_RST = 16'd2000;
    localparam logic [14:0]        SCORE_MAX        = 15'd25600;
    localparam logic [22:0]        VAR_MAX          = 23'h7FFFFF;
    localparam logic [55:0]        M2_MAX           = {56{1'b1}};
    localparam logic [31:0]        COUNT_MAX        = 32'hFFFF_FFFF;
    localparam logic signed [17:0] RSSI_OFFSET      = 18'sd23040;  // 90 dBm in q8.8
    localparam logic [22:0]        STAB_LIMIT       = 23'd12800;
    localparam logic [31:0]        GAP_ERR_LIMIT    = 32'd2000;
    // floor(x / 5) = (x * RECIP5) >> RECIP_SHIFT for x below 2^18
    localparam logic [15:0]        RECIP5           = 16'd52429;
    localparam int                 RECIP_SHIFT      = 18;

    // shared divider sizes
    localparam int DIV_NUM_W = 48;
    localparam int DIV_REM_W = 32;
    localparam int DIV_QUO_W = 23;
    localparam int DIV_CNT_W = 5;
    localparam logic [DIV_CNT_W-1:0] MEAN_DIV_ITERS = 5'd17;
    localparam logic [DIV_CNT_W-1:0] VAR_DIV_ITERS  = 5'd23;

    typedef struct packed {
        logic [1:0]  node_index;
        logic [7:0]  rssi_magnitude;
        logic [31:0] timestamp_ms;
    } rlqe_in_t;

    typedef struct packed {
        logic signed [16:0] mean_rssi;
        logic [22:0]        rssi_variance;
        logic [31:0]        interval_ms;
        logic [14:0]        link_score;
    } rlqe_out_t;

    // per-node statistics entry
    typedef struct packed {
        logic [31:0]        count;
        logic [31:0]        last_seen;
        logic [31:0]        gap;
        logic signed [16:0] mean;
        logic [55:0]        m2;
    } rlqe_entry_t;

    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] num;
        logic [DIV_REM_W-1:0] rem_init;
        logic [DIV_REM_W-1:0] divisor;
        logic [DIV_CNT_W-1:0] iters;
    } rlqe_div_req_t;

    typedef struct packed {
        logic                 done;
        logic [DIV_QUO_W-1:0] quotient;
    } rlqe_div_rsp_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_MDIV,
        ST_MUL,
        ST_ACC,
        ST_VCHK,
        ST_VDIV,
        ST_SCORE1,
        ST_SCORE2,
        ST_DONE
    } rlqe_state_t;

endpackage

`default_nettype wire

[rtl/rssi_link_quality_estimator.sv]
// ----------------------------------------------------------------------------
// rssi_link_quality_estimator
// Per-node welford mean and variance of rssi reports with a weighted
// link score; node statistics live in one synchronous memory.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake                  | beat
//  ---------+-----------+----------------------------+-----------------------
//  report   | in        | report_valid/report_stall  | node, rssi, timestamp
//  result   | out       | result_valid/result_stall  | mean, var, gap, score
//  cfg      | in        | cfg_wr_en                  | expected interval ms
//
//  an ignored report (node beyond the table) is dropped while idle; others
//  run the 17-step mean pass of the shared radix-2 divider, and the 23-step
//  variance pass when the variance divide runs, then the score states
//  reset clears per-node valid flags at once, so no clearing pass is needed
//  a new report is taken while a finished result waits in the output register
//  a stalled result holds the next report's completion in the done state
// ----------------------------------------------------------------------------
`default_nettype none

`include "rssi_link_quality_estimator_macros.svh"

module rssi_link_quality_estimator #(
    parameter int NODE_COUNT = rlqe_pkg::NODE_COUNT_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               report_valid,
    output logic               report_stall,
    input  rlqe_pkg::rlqe_in_t report,
    output logic               result_valid,
    input  logic               result_stall,
    output rlqe_pkg::rlqe_out_t result,
    input  logic               cfg_wr_en,
    input  logic [15:0]        cfg_wr_data
);
    import rlqe_pkg::*;

    localparam int ADDR_W = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;

    rlqe_state_t        state_reg, state_next;
    logic [15:0]        exp_reg;
    rlqe_in_t           item_reg;
    logic [ADDR_W-1:0]  addr_reg;
    logic [ADDR_W-1:0]  rd_addr;

    rlqe_entry_t        mem [NODE_COUNT];
    rlqe_entry_t        rd_data_reg;
    logic               rd_valid_reg;
    logic [NODE_COUNT-1:0] valid_reg;
    rlqe_entry_t        entry;
    rlqe_entry_t        wr_entry;
    logic               mem_we;

    logic [31:0]        n_reg;
    logic [31:0]        gap_reg;
    logic signed [16:0] r_reg;
    logic signed [16:0] mean_old_reg;
    logic [55:0]        m2_old_reg;
    logic signed [17:0] d_reg;
    logic signed [16:0] mean_new_reg;
    logic [31:0]        prod_reg;
    logic [55:0]        m2_new_reg;
    logic [22:0]        var_reg;
    logic [14:0]        s_rssi_reg, s_stab_reg, s_time_reg;
    logic [14:0]        score_reg;
    rlqe_out_t          result_reg;
    logic               result_valid_reg;

    logic               accept;
    logic               idx_ok;
    logic               out_free;
    rlqe_div_req_t      div_req;
    rlqe_div_rsp_t      div_rsp;

    logic [31:0]        cnt_inc;
    logic [31:0]        gap_upd;
    logic signed [16:0] r_val;
    logic signed [17:0] d_val;
    logic [17:0]        d_abs;
    logic signed [17:0] q_s;
    logic signed [17:0] q_signed;
    logic signed [17:0] mean_sum;
    logic signed [17:0] e_val;
    logic signed [35:0] prod_full;
    logic [56:0]        m2_sum;
    logic [31:0]        n_less;
    logic [47:0]        var_num;
    logic               var_big;
    logic signed [17:0] rssi_off;
    logic [17:0]        rssi_x2;
    logic [14:0]        s_rssi;
    logic [14:0]        s_stab;
    logic [31:0]        exp32;
    logic [31:0]        gap_err;
    logic [16:0]        time_x;
    logic [32:0]        time_prod;
    logic [14:0]        s_time;
    logic [17:0]        wsum;
    logic [32:0]        score_prod;

    // report handshake
    assign report_stall = (state_reg != ST_IDLE);
    assign accept       = report_valid && !report_stall;
    assign idx_ok       = (int'(report.node_index) < NODE_COUNT);
    assign rd_addr      = ADDR_W'(report.node_index);
    assign out_free     = !result_valid_reg || !result_stall;

    // entry never written reads as zero
    assign entry = rd_valid_reg ? rd_data_reg : '0;

    // count, gap and deviation from the fetched entry
    assign cnt_inc = (entry.count == COUNT_MAX) ? entry.count : entry.count + 32'd1;
    assign gap_upd = (entry.last_seen != '0) ? item_reg.timestamp_ms - entry.last_seen
                                             : entry.gap;
    assign r_val   = -$signed({1'b0, item_reg.rssi_magnitude, 8'b0});
    assign d_val   = $signed({r_val[16], r_val}) - $signed({entry.mean[16], entry.mean});
    assign d_abs   = d_val[17] ? 18'(-d_val) : 18'(d_val);

    // mean correction from the quotient magnitude
    assign q_s      = $signed({1'b0, div_rsp.quotient[16:0]});
    assign q_signed = d_reg[17] ? -q_s : q_s;
    assign mean_sum = $signed({mean_old_reg[16], mean_old_reg}) + q_signed;

    // welford product, negative clipped to zero
    assign e_val     = $signed({r_reg[16], r_reg}) - $signed({mean_new_reg[16], mean_new_reg});
    assign prod_full = d_reg * e_val;

    // saturating m2 accumulate
    assign m2_sum = {1'b0, m2_old_reg} + 57'(prod_reg);

    // variance divide setup: floor(m2 / 256) / (n - 1)
    assign n_less  = n_reg - 32'd1;
    assign var_num = m2_new_reg[55:8];
    assign var_big = ({7'b0, var_num} >= {n_less, 23'b0});

    // signal strength part
    assign rssi_off = $signed({mean_new_reg[16], mean_new_reg}) + RSSI_OFFSET;
    assign rssi_x2  = {rssi_off[16:0], 1'b0};
    assign s_rssi   = rssi_off[17] ? '0
                    : ((rssi_x2 >= 18'(SCORE_MAX)) ? SCORE_MAX : rssi_x2[14:0]);

    // stability part
    assign s_stab = (var_reg >= STAB_LIMIT) ? '0 : SCORE_MAX - {var_reg[13:0], 1'b0};

    // timing part: penalty floor(err * 64 / 5)
    assign exp32     = {16'b0, exp_reg};
    assign gap_err   = (gap_reg >= exp32) ? gap_reg - exp32 : exp32 - gap_reg;
    assign time_x    = {gap_err[10:0], 6'b0};
    assign time_prod = 33'(time_x) * 33'(RECIP5);
    assign s_time    = (gap_err >= GAP_ERR_LIMIT) ? '0
                     : SCORE_MAX - time_prod[RECIP_SHIFT+14:RECIP_SHIFT];

    // weighted sum 5:3:2, then floor(sum / 10) as floor((sum / 2) / 5)
    assign wsum       = ({3'b0, s_rssi_reg} << 2) + {3'b0, s_rssi_reg}
                      + ({3'b0, s_stab_reg} << 1) + {3'b0, s_stab_reg}
                      + ({3'b0, s_time_reg} << 1);
    assign score_prod = 33'(wsum[17:1]) * 33'(RECIP5);

    // write-back entry
    always_comb
    begin
        wr_entry.count     = n_reg;
        wr_entry.last_seen = item_reg.timestamp_ms;
        wr_entry.gap       = gap_reg;
        wr_entry.mean      = mean_new_reg;
        wr_entry.m2        = m2_new_reg;
    end

    // sequencer: next state, divider requests, write-back
    always_comb
    begin
        state_next       = state_reg;
        mem_we           = 1'b0;
        div_req.start    = 1'b0;
        div_req.num      = {d_abs[16:0], 31'b0};
        div_req.rem_init = '0;
        div_req.divisor  = cnt_inc;
        div_req.iters    = MEAN_DIV_ITERS;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && idx_ok)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                div_req.start = 1'b1;
                state_next    = ST_MDIV;
            end
            ST_MDIV:
            begin
                if (div_rsp.done)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                state_next = ST_VCHK;
            end
            ST_VCHK:
            begin
                if ((n_reg > 32'd1) && !var_big)
                begin
                    div_req.start    = 1'b1;
                    div_req.num      = {var_num[22:0], 25'b0};
                    div_req.rem_init = 32'(var_num[47:23]);
                    div_req.divisor  = n_less;
                    div_req.iters    = VAR_DIV_ITERS;
                    state_next       = ST_VDIV;
                end
                else
                begin
                    state_next = ST_SCORE1;
                end
            end
            ST_VDIV:
            begin
                if (div_rsp.done)
                begin
                    state_next = ST_SCORE1;
                end
            end
            ST_SCORE1:
            begin
                mem_we     = 1'b1;
                state_next = ST_SCORE2;
            end
            ST_SCORE2:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            exp_reg          <= EXP_INTERVAL_RST;
            result_valid_reg <= 1'b0;
            valid_reg        <= '0;
            rd_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr_en)
            begin
                exp_reg <= cfg_wr_data;
            end
            if ((state_reg == ST_DONE) && out_free)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_valid_reg && !result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
            if (mem_we)
            begin
                valid_reg[addr_reg] <= 1'b1;
            end
            if (accept && idx_ok)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    // node statistics memory, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[addr_reg] <= wr_entry;
        end
        if (accept && idx_ok)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (accept && idx_ok)
        begin
            item_reg <= report;
            addr_reg <= rd_addr;
        end
        if (state_reg == ST_READ)
        begin
            n_reg        <= cnt_inc;
            gap_reg      <= gap_upd;
            r_reg        <= r_val;
            mean_old_reg <= entry.mean;
            m2_old_reg   <= entry.m2;
            d_reg        <= d_val;
        end
        if ((state_reg == ST_MDIV) && div_rsp.done)
        begin
            mean_new_reg <= mean_sum[16:0];
        end
        if (state_reg == ST_MUL)
        begin
            prod_reg <= prod_full[35] ? '0 : prod_full[31:0];
        end
        if (state_reg == ST_ACC)
        begin
            m2_new_reg <= m2_sum[56] ? M2_MAX : m2_sum[55:0];
        end
        if (state_reg == ST_VCHK)
        begin
            var_reg <= (n_reg <= 32'd1) ? '0 : VAR_MAX;
        end
        if ((state_reg == ST_VDIV) && div_rsp.done)
        begin
            var_reg <= div_rsp.quotient;
        end
        if (state_reg == ST_SCORE1)
        begin
            s_rssi_reg <= s_rssi;
            s_stab_reg <= s_stab;
            s_time_reg <= s_time;
        end
        if (state_reg == ST_SCORE2)
        begin
            score_reg <= score_prod[RECIP_SHIFT+14:RECIP_SHIFT];
        end
        if ((state_reg == ST_DONE) && out_free)
        begin
            result_reg.mean_rssi     <= mean_new_reg;
            result_reg.rssi_variance <= var_reg;
            result_reg.interval_ms   <= gap_reg;
            result_reg.link_score    <= score_reg;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    rlqe_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // divider completions only arrive while the sequencer waits for them
    `RLQE_ASSERT_IMP(a_div_done_waited, div_rsp.done, (state_reg == ST_MDIV) || (state_reg == ST_VDIV))
    // a report for a known node starts the memory read
    `RLQE_ASSERT_NEXT(a_accept_reads, report_valid && !report_stall && idx_ok, state_reg == ST_READ)
    // a shown score never exceeds full scale
    `RLQE_ASSERT_IMP(a_score_range, result_valid_reg, result_reg.link_score <= SCORE_MAX)
    // first sample of a node reports zero variance
    `RLQE_ASSERT_NEXT(a_first_var_zero, (state_reg == ST_DONE) && out_free && (n_reg <= 32'd1), result_reg.rssi_variance == '0)

endmodule

`default_nettype wire

[rtl/rlqe_div.sv]
// ----------------------------------------------------------------------------
// rlqe_div
// Radix-2 restoring divider, one quotient bit per cycle, shared by the
// mean update and the variance.
// ----------------------------------------------------------------------------
`default_nettype none

module rlqe_div (
    input  logic                    clk,
    input  logic                    rst_n,
    input  rlqe_pkg::rlqe_div_req_t req,
    output rlqe_pkg::rlqe_div_rsp_t rsp
);
    import rlqe_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_REM_W-1:0] rem_reg, rem_next;
    logic [DIV_NUM_W-1:0] num_reg, num_next;
    logic [DIV_REM_W-1:0] den_reg, den_next;
    logic [DIV_QUO_W-1:0] quo_reg, quo_next;
    logic [DIV_REM_W:0]   shifted;
    logic                 fits;

    // trial subtract of the shifted remainder
    assign shifted = {rem_reg, num_reg[DIV_NUM_W-1]};
    assign fits    = (shifted >= {1'b0, den_reg});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        num_next  = num_reg;
        den_next  = den_reg;
        quo_next  = quo_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = req.iters;
            rem_next  = req.rem_init;
            num_next  = req.num;
            den_next  = req.divisor;
            quo_next  = '0;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? DIV_REM_W'(shifted - {1'b0, den_reg}) : shifted[DIV_REM_W-1:0];
            num_next = {num_reg[DIV_NUM_W-2:0], 1'b0};
            quo_next = {quo_reg[DIV_QUO_W-2:0], fits};
            cnt_next = cnt_reg - DIV_CNT_W'(1);
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        num_reg <= num_next;
        den_reg <= den_next;
        quo_reg <= quo_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

`default_nettype wire

[verif/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: rssi link quality estimator testbench
// Drives rssi reports through the report channel and checks every result beat
// against an in-bench model of the per-node welford statistics and the link
// score. A short directed set comes first, then phases of random per-node
// report streams under several interval settings and idle/stall mixes.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

    import rlqe_pkg::*;

    localparam int NODES          = NODE_COUNT_DEF;
    localparam int PHASES         = 8;
    localparam int ITEMS_PER_PHASE = 228;
    localparam int SHOWN_FAULTS   = 10;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 100;

    // ------------------------------------------------------------------------
    // per-node statistics and score model, plus the queue of results owed
    // ------------------------------------------------------------------------
    class link_quality_board;
        logic [31:0]        count[NODES];
        logic [31:0]        last_seen[NODES];
        logic [31:0]        gap[NODES];
        logic signed [16:0] mean[NODES];
        logic [55:0]        m2[NODES];
        logic [15:0]        interval;
        rlqe_out_t          owed_results[$];
        int unsigned        noted;
        int unsigned        checked;
        int unsigned        faults;

        function new();
            for (int i = 0; i < NODES; i++)
            begin
                count[i]     = '0;
                last_seen[i] = '0;
                gap[i]       = '0;
                mean[i]      = '0;
                m2[i]        = '0;
            end
            interval = EXP_INTERVAL_RST;
            noted    = 0;
            checked  = 0;
            faults   = 0;
        endfunction

        function void set_interval(logic [15:0] v);
            interval = v;
        endfunction

        function int pending();
            return owed_results.size();
        endfunction

        static function longint clamp_score(longint v);
            if (v < 0)
                return 0;
            if (v > longint'(SCORE_MAX))
                return longint'(SCORE_MAX);
            return v;
        endfunction

        // welford update of one node, then the weighted score
        function void note_report(rlqe_in_t rep);
            int unsigned idx;
            logic [31:0] n;
            longint      r;
            longint      d;
            longint      m;
            longint      q;
            longint      prod;
            longint      gerr;
            longint      s_rssi;
            longint      s_stab;
            longint      s_time;
            longint      score;
            logic [63:0] room;
            logic [63:0] vq;
            rlqe_out_t   res;

            idx = rep.node_index;
            noted++;
            if (count[idx] != COUNT_MAX)
                count[idx] = count[idx] + 32'd1;
            n = count[idx];

            // zero last-seen means never seen: keep the old gap
            if (last_seen[idx] != 32'd0)
                gap[idx] = rep.timestamp_ms - last_seen[idx];
            last_seen[idx] = rep.timestamp_ms;

            // mean step, quotient truncated toward zero
            r = -(longint'(rep.rssi_magnitude) * 256);
            m = mean[idx];
            d = r - m;
            q = ((d < 0) ? -d : d) / longint'(n);
            m = m + ((d < 0) ? -q : q);
            mean[idx] = m[16:0];

            // m2 accumulate, saturating
            prod = d * (r - m);
            if (prod < 0)
                prod = 0;
            room = {8'h00, M2_MAX} - {8'h00, m2[idx]};
            if (64'(prod) > room)
                m2[idx] = M2_MAX;
            else
                m2[idx] = m2[idx] + prod[55:0];

            if (n > 32'd1)
            begin
                vq = {8'h00, m2[idx]} / ({32'h0, n - 32'd1} * 64'd256);
                if (vq > 64'(VAR_MAX))
                    vq = 64'(VAR_MAX);
            end
            else
                vq = '0;

            // score parts
            s_rssi = clamp_score(2 * (m + longint'(RSSI_OFFSET)));
            s_stab = clamp_score(longint'(SCORE_MAX) - 2 * longint'(vq));
            gerr   = longint'(gap[idx]) - longint'(interval);
            if (gerr < 0)
                gerr = -gerr;
            s_time = clamp_score(longint'(SCORE_MAX) - (gerr * 256) / 20);
            score  = (5 * s_rssi + 3 * s_stab + 2 * s_time) / 10;

            res.mean_rssi     = m[16:0];
            res.rssi_variance = vq[22:0];
            res.interval_ms   = gap[idx];
            res.link_score    = score[14:0];
            owed_results.push_back(res);
        endfunction

        // compare one result beat with the oldest owed result
        function void check_result(rlqe_out_t got);
            rlqe_out_t want;

            if (owed_results.size() == 0)
            begin
                faults++;
                if (faults <= SHOWN_FAULTS)
                    $display("tb_top: result beat with none owed: mean %0d var %0d gap %0d score %0d",
                             got.mean_rssi, got.rssi_variance, got.interval_ms, got.link_score);
                return;
            end
            want = owed_results.pop_front();
            checked++;
            if (got.mean_rssi !== want.mean_rssi || got.rssi_variance !== want.rssi_variance ||
                got.interval_ms !== want.interval_ms || got.link_score !== want.link_score)
            begin
                faults++;
                if (faults <= SHOWN_FAULTS)
                begin
                    $write("tb_top: result %0d wrong (expected/actual): ", checked);
                    $display("mean %0d/%0d var %0d/%0d gap %0d/%0d score %0d/%0d",
                             want.mean_rssi, got.mean_rssi, want.rssi_variance,
                             got.rssi_variance, want.interval_ms, got.interval_ms,
                             want.link_score, got.link_score);
                end
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // block and its signals
    // ------------------------------------------------------------------------
    logic        clk;
    logic        rst_n;
    logic        report_valid;
    logic        report_stall;
    rlqe_in_t    report;
    logic        result_valid;
    logic        result_stall;
    rlqe_out_t   result;
    logic        cfg_wr_en;
    logic [15:0] cfg_wr_data;

    rssi_link_quality_estimator DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .report_valid (report_valid),
        .report_stall (report_stall),
        .report       (report),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data)
    );

    link_quality_board board;
    int                send_idle_pct;
    int                stall_pct;
    int unsigned       reports_sent;
    int unsigned       quiet_cycles;
    logic [15:0]       cur_interval;
    logic [31:0]       node_clock[NODES];
    int                base_mag[NODES];

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // known values on every input from time zero
    initial
    begin
        rst_n        = 1'b0;
        report_valid = 1'b0;
        report       = '0;
        result_stall = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_wr_data  = '0;
    end

    // receiver stall, redrawn every cycle
    always @(negedge clk)
        result_stall = ($urandom_range(0, 99) < stall_pct);

    // beat monitors
    always @(posedge clk)
    begin
        if (rst_n && report_valid && !report_stall)
            board.note_report(report);
        if (rst_n && result_valid && !result_stall)
            board.check_result(result);
    end

    // watchdog on cycles with no beat on either channel
    always @(posedge clk)
    begin
        if ((report_valid && !report_stall) || (result_valid && !result_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb_top: no beat for %0d cycles, %0d results still owed",
                     quiet_cycles, board.pending());
            $display("tb_top: done, errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // driving tasks, entered and left at a falling edge
    // ------------------------------------------------------------------------
    task automatic send_report(input rlqe_in_t item);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            report_valid = 1'b0;
            report       = rlqe_in_t'({$urandom, $urandom});
            @(negedge clk);
        end
        report_valid = 1'b1;
        report       = item;
        @(posedge clk);
        while (report_stall)
            @(posedge clk);
        reports_sent++;
        @(negedge clk);
    endtask

    task automatic wait_drain();
        report_valid = 1'b0;
        while (board.pending() != 0)
            @(negedge clk);
    endtask

    task automatic write_interval(input logic [15:0] v);
        wait_drain();
        repeat (4) @(negedge clk);
        cfg_wr_en   = 1'b1;
        cfg_wr_data = v;
        @(negedge clk);
        cfg_wr_en   = 1'b0;
        board.set_interval(v);
        cur_interval = v;
    endtask

    function automatic rlqe_in_t mk_report(logic [1:0] node, logic [7:0] mag, logic [31:0] ts);
        rlqe_in_t item;
        item.node_index     = node;
        item.rssi_magnitude = mag;
        item.timestamp_ms   = ts;
        return item;
    endfunction

    // mostly steady per-node streams near the nominal interval, some noise
    function automatic rlqe_in_t next_report();
        rlqe_in_t item;
        int       node;
        int       kind;
        int       jitter;
        int       mag;

        node = $urandom_range(0, NODES - 1);
        kind = $urandom_range(0, 99);
        if (kind < 80)
        begin
            jitter = int'($urandom_range(0, 4200)) - 2100;
            node_clock[node] = node_clock[node] + cur_interval + jitter;
        end
        else if (kind < 88)
            node_clock[node] = $urandom;
        else if (kind < 92)
            node_clock[node] = 32'd0;
        else
            node_clock[node] = node_clock[node] + $urandom_range(0, 400000);

        if ($urandom_range(0, 49) == 0)
            base_mag[node] = $urandom_range(0, 255);
        if ($urandom_range(0, 3) != 0)
        begin
            mag = base_mag[node] + int'($urandom_range(0, 12)) - 6;
            if (mag < 0)
                mag = 0;
            if (mag > 255)
                mag = 255;
        end
        else
            mag = $urandom_range(0, 255);

        item.node_index     = node[1:0];
        item.rssi_magnitude = mag[7:0];
        item.timestamp_ms   = node_clock[node];
        return item;
    endfunction

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        int          phase;
        int          k;
        logic [15:0] iv;

        board         = new();
        send_idle_pct = 0;
        stall_pct     = 0;
        reports_sent  = 0;
        quiet_cycles  = 0;
        cur_interval  = EXP_INTERVAL_RST;
        for (int i = 0; i < NODES; i++)
        begin
            node_clock[i] = $urandom_range(1, 100000);
            base_mag[i]   = $urandom_range(0, 255);
        end

        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed reports at the reset interval
        send_report(mk_report(2'd0, 8'd0, 32'd0));              // first report, zero time
        send_report(mk_report(2'd0, 8'd255, 32'd1000));         // last seen zero, gap kept
        send_report(mk_report(2'd0, 8'd255, 32'd3000));         // gap equals interval
        send_report(mk_report(2'd0, 8'd0, 32'd3001));
        send_report(mk_report(2'd1, 8'd255, 32'hFFFF_FFFF));
        send_report(mk_report(2'd1, 8'd255, 32'h0000_0005));    // time wraps
        send_report(mk_report(2'd1, 8'd255, 32'h8000_0005));
        send_report(mk_report(2'd1, 8'd127, 32'd0));            // zero time again
        send_report(mk_report(2'd1, 8'd64, 32'd9000));          // old gap kept
        send_report(mk_report(2'd2, 8'd90, 32'd100));
        send_report(mk_report(2'd2, 8'd90, 32'd2100));          // mean at -90 dbm
        send_report(mk_report(2'd2, 8'd90, 32'd4100));
        send_report(mk_report(2'd2, 8'd77, 32'd6100));
        send_report(mk_report(2'd2, 8'd1, 32'd8100));
        send_report(mk_report(2'd3, 8'd0, 32'd7));              // wide swings, high variance
        send_report(mk_report(2'd3, 8'd255, 32'd2007));
        send_report(mk_report(2'd3, 8'd0, 32'd4007));
        send_report(mk_report(2'd3, 8'd255, 32'd6007));
        send_report(mk_report(2'd3, 8'd170, 32'hAAAA_AAAA));
        send_report(mk_report(2'd3, 8'd85, 32'h5555_5555));
        send_report(mk_report(2'd0, 8'd128, 32'd5000));
        send_report(mk_report(2'd2, 8'd200, 32'h0000_FFFF));

        // random phases: interval setting and idle mix change per phase
        for (phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0, 6:    iv = 16'd0;
                1, 5:    iv = 16'hFFFF;
                2:       iv = EXP_INTERVAL_RST;
                4:       iv = 16'd1000;
                default: iv = 16'($urandom_range(1, 65534));
            endcase
            write_interval(iv);
            case (phase % 4)
                0:       begin send_idle_pct = 0;  stall_pct = 0;  end
                1:       begin send_idle_pct = 70; stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  stall_pct = 70; end
                default: begin send_idle_pct = 12; stall_pct = 12; end
            endcase
            for (k = 0; k < ITEMS_PER_PHASE; k++)
            begin
                // sender holds off until the block has caught up
                if (k == ITEMS_PER_PHASE / 2)
                    wait_drain();
                send_report(next_report());
            end
        end

        // drain, then watch for stray result beats
        wait_drain();
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("tb_top: %0d reports sent, %0d results checked, %0d faults",
                 reports_sent, board.checked, board.faults);
        $display("tb_top: intervals 0, 1000, 2000, 65535 and random; idle mixes none, sender, receiver, both");
        if (board.faults == 0 && board.pending() == 0 && board.noted == reports_sent)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule

`default_nettype wire

[files.f]
+incdir+rtl
rtl/rlqe_pkg.sv
rtl/rlqe_div.sv
rtl/rssi_link_quality_estimator.sv
verif/tb_top.sv
